// File: rtl/length_prefixed_message_deframer_assert.svh
// ----------------------------------------------------------------------------
// Deframer assertion macros
// Concurrent assertion wrappers shared by the deframer RTL. They compile to
// nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_MESSAGE_DEFRAMER_ASSERT_SVH
`define LENGTH_PREFIXED_MESSAGE_DEFRAMER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define LPMD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LPMD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer assertion failed");

`else

`define LPMD_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define LPMD_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/lpmd_pkg.sv
// ----------------------------------------------------------------------------
// Deframer package
// Constants, result codes and the result record shared by the deframer RTL.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lpmd_pkg;

    localparam logic [31:0] MAX_FRAME_BYTES  = 32'd4096;
    localparam logic [31:0] INNER_HEAD_BYTES = 32'd8;
    localparam int          BLEN_W           = 12;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_BODY   = 2'd1;
    localparam logic [1:0] KIND_DROP   = 2'd2;

    localparam logic [1:0] REASON_NONE      = 2'd0;
    localparam logic [1:0] REASON_SHORT     = 2'd1;
    localparam logic [1:0] REASON_LONG      = 2'd2;
    localparam logic [1:0] REASON_INNER_LEN = 2'd3;

    typedef struct packed {
        logic [1:0]        kind;
        logic [31:0]       msg_id;
        logic [BLEN_W-1:0] body_length;
        logic [7:0]        body_byte;
        logic [BLEN_W-1:0] byte_index;
        logic [1:0]        drop_reason;
        logic              last;
    } t_result;

endpackage

`default_nettype wire

// File: rtl/lpmd_parser.sv
// ----------------------------------------------------------------------------
// Deframer parser
// Frame state and the per-byte update; one byte is consumed per step and at
// most one result record is produced for it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lpmd_parser (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_step,
    input  wire logic [7:0]       i_byte,
    output logic                  o_res_valid,
    output lpmd_pkg::t_result     o_res
);
    import lpmd_pkg::*;

    localparam logic [2:0] PH_OUTER = 3'd0;
    localparam logic [2:0] PH_ID    = 3'd1;
    localparam logic [2:0] PH_BLEN  = 3'd2;
    localparam logic [2:0] PH_BODY  = 3'd3;
    localparam logic [2:0] PH_SKIP  = 3'd4;

    logic [2:0]        r_phase, n_phase;
    logic [1:0]        r_cnt,   n_cnt;
    logic [31:0]       r_shift, n_shift;
    logic [31:0]       r_rem,   n_rem;
    logic [31:0]       r_id,    n_id;
    logic [BLEN_W-1:0] r_blen,  n_blen;
    logic [BLEN_W-1:0] r_pos,   n_pos;

    logic [31:0]       field;
    logic              field_done;
    logic [31:0]       rem_dec;
    logic              fin;

    assign field      = {r_shift[23:0], i_byte};
    assign field_done = (r_cnt == 2'd3);
    assign rem_dec    = (r_rem != 32'd0) ? r_rem - 32'd1 : r_rem;
    assign fin        = ({1'b0, r_pos} + {{BLEN_W{1'b0}}, 1'b1}) >= {1'b0, r_blen};

    always_comb begin
        n_phase     = r_phase;
        n_cnt       = r_cnt;
        n_shift     = r_shift;
        n_rem       = r_rem;
        n_id        = r_id;
        n_blen      = r_blen;
        n_pos       = r_pos;
        o_res_valid = 1'b0;
        o_res       = '0;

        case (r_phase)
            PH_OUTER: begin
                n_cnt   = r_cnt + 2'd1;
                n_shift = field;
                if (field_done) begin
                    n_rem   = field;
                    n_shift = 32'd0;
                    n_id    = 32'd0;
                    n_blen  = '0;
                    n_pos   = '0;
                    if (field == 32'd0) begin
                        n_phase = PH_OUTER;
                    end else if (field < INNER_HEAD_BYTES) begin
                        n_phase           = PH_SKIP;
                        o_res_valid       = 1'b1;
                        o_res.kind        = KIND_DROP;
                        o_res.drop_reason = REASON_SHORT;
                        o_res.last        = 1'b1;
                    end else if (field > MAX_FRAME_BYTES) begin
                        n_phase           = PH_SKIP;
                        o_res_valid       = 1'b1;
                        o_res.kind        = KIND_DROP;
                        o_res.drop_reason = REASON_LONG;
                        o_res.last        = 1'b1;
                    end else begin
                        n_phase = PH_ID;
                    end
                end
            end
            PH_ID: begin
                n_rem   = rem_dec;
                n_cnt   = r_cnt + 2'd1;
                n_shift = field;
                if (field_done) begin
                    n_id    = field;
                    n_shift = 32'd0;
                    n_phase = PH_BLEN;
                end
            end
            PH_BLEN: begin
                n_rem   = rem_dec;
                n_cnt   = r_cnt + 2'd1;
                n_shift = field;
                if (field_done) begin
                    n_shift      = 32'd0;
                    o_res_valid  = 1'b1;
                    o_res.msg_id = r_id;
                    o_res.last   = 1'b1;
                    if (field > rem_dec) begin
                        o_res.kind        = KIND_DROP;
                        o_res.drop_reason = REASON_INNER_LEN;
                        n_phase           = (rem_dec == 32'd0) ? PH_OUTER : PH_SKIP;
                    end else begin
                        // The compare above bounds the inner length to the frame.
                        n_blen            = field[BLEN_W-1:0];
                        n_pos             = '0;
                        o_res.kind        = KIND_HEADER;
                        o_res.body_length = field[BLEN_W-1:0];
                        if (field == 32'd0) begin
                            n_phase = (rem_dec == 32'd0) ? PH_OUTER : PH_SKIP;
                        end else begin
                            o_res.last = 1'b0;
                            n_phase    = PH_BODY;
                        end
                    end
                end
            end
            PH_BODY: begin
                n_rem             = rem_dec;
                n_pos             = r_pos + {{(BLEN_W-1){1'b0}}, 1'b1};
                o_res_valid       = 1'b1;
                o_res.kind        = KIND_BODY;
                o_res.msg_id      = r_id;
                o_res.body_length = r_blen;
                o_res.body_byte   = i_byte;
                o_res.byte_index  = r_blen - {{(BLEN_W-1){1'b0}}, 1'b1} - r_pos;
                o_res.last        = fin;
                if (fin) begin
                    n_phase = (rem_dec == 32'd0) ? PH_OUTER : PH_SKIP;
                    n_cnt   = 2'd0;
                    n_shift = 32'd0;
                end
            end
            default: begin
                // Skip phase, and any code that should never occur.
                n_rem = rem_dec;
                if (rem_dec == 32'd0) begin
                    n_phase = PH_OUTER;
                    n_cnt   = 2'd0;
                    n_shift = 32'd0;
                end else begin
                    n_phase = PH_SKIP;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_OUTER;
            r_cnt   <= 2'd0;
            r_shift <= 32'd0;
            r_rem   <= 32'd0;
            r_id    <= 32'd0;
            r_blen  <= '0;
            r_pos   <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_shift <= n_shift;
            r_rem   <= n_rem;
            r_id    <= n_id;
            r_blen  <= n_blen;
            r_pos   <= n_pos;
        end
    end

endmodule

`default_nettype wire

// File: rtl/length_prefixed_message_deframer.sv
// ----------------------------------------------------------------------------
// Length-prefixed message deframer
// Parses a byte stream of length-prefixed frames into header, body byte and
// drop records.
// ----------------------------------------------------------------------------
// Usage:
// Raw stream bytes enter on the input channel (i_in_valid / o_in_ready /
// i_data_byte), one byte per transfer. Each byte yields zero or one result
// record on the output channel (o_out_valid / i_out_ready and the o_ fields).
// A record appears on the output after its byte transfer: the byte waits in
// the input register while the parser works on it, and the result register
// is loaded from the parser when it is free or drains.
// Throughput is one byte per cycle while the receiver does not stall; the
// parser updates its frame state once per byte. Bytes with no record (length
// and id fields, trailing frame bytes, skipped frames) still pass both stages.
// When the receiver stalls, the result register holds its record, the input
// register holds the next byte, and o_in_ready drops once both are full.
// Synchronous reset clears the parser to wait for an outer length field and
// empties both registers; no record is pending after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "length_prefixed_message_deframer_assert.svh"

module length_prefixed_message_deframer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_data_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_kind,
    output logic [31:0]      o_msg_id,
    output logic [11:0]      o_body_length,
    output logic [7:0]       o_body_byte,
    output logic [11:0]      o_byte_index,
    output logic [1:0]       o_drop_reason,
    output logic             o_last
);
    import lpmd_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;

    logic       advance;
    logic       step;
    logic       res_valid;
    t_result    res;

    // The parser stage moves whenever the result register is free or drains.
    assign advance    = !r_out_valid || i_out_ready;
    assign step       = r_in_valid && advance;
    assign o_in_ready = !r_in_valid || advance;

    lpmd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_byte      (r_in_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= step && res_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_in_byte <= i_data_byte;
        end
        if (advance) begin
            r_out <= res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_out.kind;
    assign o_msg_id      = r_out.msg_id;
    assign o_body_length = r_out.body_length;
    assign o_body_byte   = r_out.body_byte;
    assign o_byte_index  = r_out.byte_index;
    assign o_drop_reason = r_out.drop_reason;
    assign o_last        = r_out.last;

    `LPMD_ASSERT_IMP(a_drop_is_last, i_clk, i_rst_n, o_out_valid && o_kind == KIND_DROP, o_last)
    `LPMD_ASSERT_IMP(a_last_body_index_zero, i_clk, i_rst_n, o_out_valid && o_kind == KIND_BODY && o_last, o_byte_index == 12'd0)
    `LPMD_ASSERT_IMP(a_reason_only_on_drop, i_clk, i_rst_n, o_out_valid && o_kind != KIND_DROP, o_drop_reason == REASON_NONE)
    `LPMD_ASSERT_NXT(a_input_held_on_stall, i_clk, i_rst_n, r_in_valid && !advance, r_in_valid && $stable(r_in_byte))

endmodule

`default_nettype wire
